[rtl/mmnp_pkg.sv]
// shared constants, types and tables of the music macro note parser
package mmnp_pkg;

    // width of the character position counter; error positions saturate at 16 bits
    localparam int POS_BITS   = 16;
    localparam int ERR_POS_W  = 16;
    localparam int FREQ_W     = 15;
    localparam int DUR_W      = 10;
    localparam int KIND_W     = 2;
    localparam int TDATA_W    = 48;
    localparam int BASE_W     = 30;
    localparam int FREQ_ACC_W = BASE_W + 15;
    localparam int FRAC_BITS  = 24;

    // result kinds carried on tuser
    localparam logic [KIND_W-1:0] KIND_TONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // parser modes
    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_OCT  = 2'd1;
    localparam logic [1:0] MODE_SKIP = 2'd2;

    // held note codes and accidentals
    localparam logic [2:0] NOTE_REST = 3'd7;
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_SHARP = 2'd1;
    localparam logic [1:0] ACC_FLAT  = 2'd2;

    // duration divider
    localparam logic [DUR_W-1:0] DUR_DIVIDEND = 10'd1000;
    localparam logic [3:0]       DIV_STEPS    = 4'd10;

    localparam logic [3:0] OCTAVE_RESET = 4'd4;
    localparam logic [6:0] LENGTH_RESET = 7'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic apply;
        logic snap_held;
        logic div_start;
        logic div_step;
        logic load_tone;
        logic load_err;
        logic load_done;
        logic out_last;
        logic clear;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic tone_req;
        logic err_req;
        logic last;
        logic skip;
        logic flush_ok;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // semitone index from note code and accidental
    function automatic logic [3:0] semi_index(input logic [2:0] note, input logic [1:0] acc);
        logic [3:0] base;
        begin
            unique case (note)
                3'd0:    base = 4'd1;
                3'd1:    base = 4'd3;
                3'd2:    base = 4'd5;
                3'd3:    base = 4'd6;
                3'd4:    base = 4'd8;
                3'd5:    base = 4'd10;
                3'd6:    base = 4'd12;
                default: base = 4'd0;
            endcase
            if (acc == ACC_SHARP)
                semi_index = base + 4'd1;
            else if (acc == ACC_FLAT)
                semi_index = base - 4'd1;
            else
                semi_index = base;
        end
    endfunction

    // octave zero semitone frequencies, unsigned q6.24
    function automatic logic [BASE_W-1:0] base_q24(input logic [3:0] idx);
        begin
            unique case (idx)
                4'd0:    base_q24 = 30'd258937088;
                4'd1:    base_q24 = 30'd274334289;
                4'd2:    base_q24 = 30'd290647054;
                4'd3:    base_q24 = 30'd307929828;
                4'd4:    base_q24 = 30'd326240288;
                4'd5:    base_q24 = 30'd345639545;
                4'd6:    base_q24 = 30'd366192342;
                4'd7:    base_q24 = 30'd387967272;
                4'd8:    base_q24 = 30'd411037006;
                4'd9:    base_q24 = 30'd435478539;
                4'd10:   base_q24 = 30'd461373440;
                4'd11:   base_q24 = 30'd488808132;
                4'd12:   base_q24 = 30'd517874176;
                4'd13:   base_q24 = 30'd548668578;
                default: base_q24 = '0;
            endcase
        end
    endfunction

    // note code of a letter A-G given as offset from A
    function automatic logic [2:0] letter_note(input logic [2:0] ofs);
        begin
            unique case (ofs)
                3'd0:    letter_note = 3'd5;
                3'd1:    letter_note = 3'd6;
                3'd2:    letter_note = 3'd0;
                3'd3:    letter_note = 3'd1;
                3'd4:    letter_note = 3'd2;
                3'd5:    letter_note = 3'd3;
                3'd6:    letter_note = 3'd4;
                default: letter_note = 3'd0;
            endcase
        end
    endfunction

endpackage

[rtl/mmnp_ctrl.sv]
// controller state machine of the music macro note parser
module mmnp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  mmnp_pkg::dp_stat_t stat,
    output mmnp_pkg::dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EVAL   = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_TONE   = 7'b0001000,
        ST_ERR    = 7'b0010000,
        ST_ENDCHK = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.apply     = 1'b1;
                cmd.div_start = 1'b1;
                flush_next    = 1'b0;
                if (stat.tone_req)
                    state_next = ST_DIV;
                else if (stat.err_req)
                    state_next = ST_ERR;
                else
                    state_next = ST_ENDCHK;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_TONE;
                else
                    cmd.div_step = 1'b1;
            end
            ST_TONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_tone = 1'b1;
                    cmd.out_last  = !flush_reg && !stat.last;
                    state_next    = flush_reg ? ST_DONE : ST_ENDCHK;
                end
            end
            ST_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_err = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_ENDCHK;
                end
            end
            ST_ENDCHK:
            begin
                if (!stat.last)
                    state_next = ST_IDLE;
                else if (stat.skip)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.flush_ok)
                begin
                    cmd.snap_held = 1'b1;
                    cmd.div_start = 1'b1;
                    flush_next    = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_done = 1'b1;
                    cmd.out_last  = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

endmodule

[rtl/mmnp_dp.sv]
// datapath of the music macro note parser: parse state, divider, tone lookup, output beat
module mmnp_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mmnp_pkg::dp_cmd_t         cmd,
    output mmnp_pkg::dp_stat_t        stat,
    input  logic [7:0]                s_char,
    input  logic                      s_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [mmnp_pkg::TDATA_W-1:0] m_data,
    output logic [mmnp_pkg::KIND_W-1:0]  m_kind,
    output logic                      m_last
);

    // captured character
    logic [7:0] char_reg;
    logic       last_reg;

    // per-string parse state
    logic [1:0]                    mode_reg, mode_next;
    logic [3:0]                    oct_reg, oct_next;
    logic [2:0]                    note_reg, note_next;
    logic [1:0]                    acc_reg, acc_next;
    logic [6:0]                    len_reg, len_next;
    logic                          pending_reg, pending_next;
    logic                          given_reg, given_next;
    logic [mmnp_pkg::POS_BITS-1:0] pos_reg, pos_next;

    // tone snapshot and error position
    logic [2:0]                    snap_note_reg;
    logic [1:0]                    snap_acc_reg;
    logic [6:0]                    snap_len_reg;
    logic [3:0]                    snap_oct_reg;
    logic [mmnp_pkg::POS_BITS-1:0] err_pos_reg;

    // divider
    logic [mmnp_pkg::DUR_W-1:0] quot_reg;
    logic [6:0]                 rem_reg;
    logic [3:0]                 cnt_reg;

    // output beat
    logic                           out_valid_reg;
    logic [mmnp_pkg::KIND_W-1:0]    out_kind_reg;
    logic [mmnp_pkg::FREQ_W-1:0]    out_freq_reg;
    logic [mmnp_pkg::DUR_W-1:0]     out_dur_reg;
    logic [mmnp_pkg::ERR_POS_W-1:0] out_pos_reg;
    logic                           out_last_reg;

    // decode results
    logic [7:0] up;
    logic       is_digit, is_note, is_oct, is_acc;
    logic [3:0] digit;
    logic [9:0] len_x10;
    logic [6:0] len_two;
    logic [1:0] ev_mode;
    logic [3:0] ev_oct;
    logic [2:0] ev_note;
    logic [1:0] ev_acc;
    logic [6:0] ev_len;
    logic       ev_pending, ev_given, ev_sound, ev_err, ev_two;
    logic [6:0] ev_snap_len;

    // character classes
    always_comb
    begin
        up       = (char_reg >= 8'h61 && char_reg <= 8'h7a) ? char_reg - 8'd32 : char_reg;
        is_digit = (char_reg >= 8'h30 && char_reg <= 8'h39);
        is_note  = (up >= 8'h41 && up <= 8'h47) || (up == 8'h52);
        is_oct   = (up == 8'h4f);
        is_acc   = (char_reg == 8'h23) || (char_reg == 8'h2b) || (char_reg == 8'h2d);
        digit    = char_reg[3:0];
        len_x10  = 10'({len_reg, 3'b000}) + 10'({len_reg, 1'b0}) + 10'(digit);
        len_two  = len_x10[6:0];
    end

    // parse one character
    always_comb
    begin
        ev_mode    = mode_reg;
        ev_oct     = oct_reg;
        ev_note    = note_reg;
        ev_acc     = acc_reg;
        ev_len     = len_reg;
        ev_pending = pending_reg;
        ev_given   = given_reg;
        ev_sound   = 1'b0;
        ev_err     = 1'b0;
        ev_two     = 1'b0;
        if (mode_reg == mmnp_pkg::MODE_OCT)
        begin
            if (is_digit)
            begin
                ev_oct  = digit;
                ev_mode = mmnp_pkg::MODE_CMD;
            end
            else
                ev_err = 1'b1;
        end
        else if (mode_reg == mmnp_pkg::MODE_CMD)
        begin
            if (is_note)
            begin
                ev_sound   = pending_reg;
                ev_note    = (up == 8'h52) ? mmnp_pkg::NOTE_REST
                                           : mmnp_pkg::letter_note(3'(up - 8'h41));
                ev_acc     = mmnp_pkg::ACC_NONE;
                ev_len     = mmnp_pkg::LENGTH_RESET;
                ev_pending = 1'b1;
                ev_given   = 1'b0;
            end
            else if (is_oct)
            begin
                if (pending_reg)
                begin
                    ev_sound   = 1'b1;
                    ev_pending = 1'b0;
                    ev_given   = 1'b0;
                end
                ev_mode = mmnp_pkg::MODE_OCT;
            end
            else if (pending_reg)
            begin
                if (!given_reg)
                begin
                    if (is_acc && note_reg != mmnp_pkg::NOTE_REST)
                        ev_acc = (char_reg == 8'h2d) ? mmnp_pkg::ACC_FLAT : mmnp_pkg::ACC_SHARP;
                    else if (is_digit)
                    begin
                        ev_len   = 7'(digit);
                        ev_given = 1'b1;
                    end
                    else
                        ev_err = 1'b1;
                end
                else if (is_digit)
                begin
                    ev_len     = len_two;
                    ev_two     = 1'b1;
                    ev_sound   = 1'b1;
                    ev_pending = 1'b0;
                    ev_given   = 1'b0;
                end
                else
                    ev_err = 1'b1;
            end
        end
        if (ev_err)
            ev_mode = mmnp_pkg::MODE_SKIP;
        ev_snap_len = ev_two ? len_two : len_reg;
    end

    // next parse state
    always_comb
    begin
        mode_next    = mode_reg;
        oct_next     = oct_reg;
        note_next    = note_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        pending_next = pending_reg;
        given_next   = given_reg;
        pos_next     = pos_reg;
        if (cmd.clear)
        begin
            mode_next    = mmnp_pkg::MODE_CMD;
            oct_next     = mmnp_pkg::OCTAVE_RESET;
            note_next    = '0;
            acc_next     = mmnp_pkg::ACC_NONE;
            len_next     = mmnp_pkg::LENGTH_RESET;
            pending_next = 1'b0;
            given_next   = 1'b0;
            pos_next     = '0;
        end
        else if (cmd.apply)
        begin
            mode_next    = ev_mode;
            oct_next     = ev_oct;
            note_next    = ev_note;
            acc_next     = ev_acc;
            len_next     = ev_len;
            pending_next = ev_pending;
            given_next   = ev_given;
            if (pos_reg != '1)
                pos_next = pos_reg + 1'b1;
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= mmnp_pkg::MODE_CMD;
            oct_reg     <= mmnp_pkg::OCTAVE_RESET;
            note_reg    <= '0;
            acc_reg     <= mmnp_pkg::ACC_NONE;
            len_reg     <= mmnp_pkg::LENGTH_RESET;
            pending_reg <= 1'b0;
            given_reg   <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            oct_reg     <= oct_next;
            note_reg    <= note_next;
            acc_reg     <= acc_next;
            len_reg     <= len_next;
            pending_reg <= pending_next;
            given_reg   <= given_next;
            pos_reg     <= pos_next;
        end
    end

    // character capture and tone snapshot
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg <= s_char;
            last_reg <= s_last;
        end
        if (cmd.apply)
        begin
            snap_note_reg <= note_reg;
            snap_acc_reg  <= acc_reg;
            snap_len_reg  <= ev_snap_len;
            snap_oct_reg  <= oct_reg;
            err_pos_reg   <= pos_reg;
        end
        else if (cmd.snap_held)
        begin
            snap_note_reg <= note_reg;
            snap_acc_reg  <= acc_reg;
            snap_len_reg  <= len_reg;
            snap_oct_reg  <= oct_reg;
        end
    end

    // restoring divider, one quotient bit per step
    logic [7:0] trial;
    logic       take;
    logic [7:0] diff;

    always_comb
    begin
        trial = {rem_reg, quot_reg[mmnp_pkg::DUR_W-1]};
        take  = trial >= {1'b0, snap_len_reg};
        diff  = trial - {1'b0, snap_len_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quot_reg <= mmnp_pkg::DUR_DIVIDEND;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[mmnp_pkg::DUR_W-2:0], take};
            rem_reg  <= take ? diff[6:0] : trial[6:0];
            cnt_reg  <= cnt_reg + 4'd1;
        end
    end

    // frequency: table value scaled by octave, rounded half up
    logic [3:0]                      semi;
    logic [mmnp_pkg::FREQ_ACC_W-1:0] scaled;
    logic [mmnp_pkg::FREQ_ACC_W-1:0] rounded;
    logic [mmnp_pkg::FREQ_W-1:0]     freq;

    always_comb
    begin
        semi    = mmnp_pkg::semi_index(snap_note_reg, snap_acc_reg);
        scaled  = mmnp_pkg::FREQ_ACC_W'(mmnp_pkg::base_q24(semi)) << snap_oct_reg;
        rounded = scaled + (mmnp_pkg::FREQ_ACC_W'(1) << (mmnp_pkg::FRAC_BITS - 1));
        if (snap_note_reg == mmnp_pkg::NOTE_REST)
            freq = '0;
        else
            freq = rounded[mmnp_pkg::FRAC_BITS +: mmnp_pkg::FREQ_W];
    end

    // saturated error position
    logic [31:0]                    pos_ext;
    logic [mmnp_pkg::ERR_POS_W-1:0] pos_sat;

    always_comb
    begin
        pos_ext = 32'(err_pos_reg);
        pos_sat = (pos_ext > 32'd65535) ? '1 : pos_ext[mmnp_pkg::ERR_POS_W-1:0];
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_tone || cmd.load_err || cmd.load_done)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_tone)
        begin
            out_kind_reg <= mmnp_pkg::KIND_TONE;
            out_freq_reg <= freq;
            out_dur_reg  <= quot_reg;
            out_pos_reg  <= '0;
            out_last_reg <= cmd.out_last;
        end
        else if (cmd.load_err)
        begin
            out_kind_reg <= mmnp_pkg::KIND_ERR;
            out_freq_reg <= '0;
            out_dur_reg  <= '0;
            out_pos_reg  <= pos_sat;
            out_last_reg <= cmd.out_last;
        end
        else if (cmd.load_done)
        begin
            out_kind_reg <= mmnp_pkg::KIND_DONE;
            out_freq_reg <= '0;
            out_dur_reg  <= '0;
            out_pos_reg  <= '0;
            out_last_reg <= cmd.out_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_last  = out_last_reg;
    assign m_data  = {7'b0, out_pos_reg, out_dur_reg, out_freq_reg};

    // status to the controller
    always_comb
    begin
        stat.tone_req = ev_sound && (ev_snap_len != '0);
        stat.err_req  = ev_err;
        stat.last     = last_reg;
        stat.skip     = (mode_reg == mmnp_pkg::MODE_SKIP);
        stat.flush_ok = pending_reg && (len_reg != '0);
        stat.div_done = (cnt_reg == mmnp_pkg::DIV_STEPS);
        stat.out_free = !out_valid_reg || m_ready;
    end

endmodule

[rtl/music_macro_note_parser.sv]
// top level of the music macro note parser
// Takes a music macro string one character per input beat (tlast on the last
// character) and gives tone beats (frequency in Hz, duration 1000/length ms),
// a done beat at the end of a clean string, or one error beat with the
// character position, after which the rest of the string is skipped. tuser
// carries the result kind and tlast marks the last result beat caused by one
// character. One character is in work at a time: a character that gives no
// result passes through the evaluate and end-check states, each tone beat
// adds a run of the one-bit-per-cycle duration divider, and any result beat
// may wait for the output register to drain. The output register lets the
// next character be taken while the last result still waits.
module music_macro_note_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // freq_hz[14:0], dur_ms[24:15], error_pos[40:25], zeros
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    mmnp_pkg::dp_cmd_t  cmd;
    mmnp_pkg::dp_stat_t stat;

    // sequencing
    mmnp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // parse state and arithmetic
    mmnp_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_char  (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_kind  (m_axis_tuser),
        .m_last  (m_axis_tlast)
    );

    // done and error beats always close the run of a character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == mmnp_pkg::KIND_DONE || m_axis_tuser == mmnp_pkg::KIND_ERR)
        |-> m_axis_tlast)
        else $error("done or error beat without tlast");

    // a tone never has zero duration
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == mmnp_pkg::KIND_TONE |-> m_axis_tdata[24:15] != '0)
        else $error("tone beat with zero duration");

    // only tone beats carry a frequency or duration
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != mmnp_pkg::KIND_TONE |-> m_axis_tdata[24:0] == '0)
        else $error("non-tone beat carries tone payload");

    // no new character is taken in the cycle right after one was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("character taken while previous one in work");

endmodule

[test/music_macro_note_parser_tb.sv]
// self-checking testbench for the music macro note parser, with its own parse predictor
module music_macro_note_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 400;
    localparam int ITEM_TARGET   = 267;
    localparam int SETTLE_CYCLES = 60;

    // characters with a meaning to the parser
    localparam logic [7:0] CH_SHARP = "#";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_FLAT  = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_OCT   = "O";
    localparam logic [7:0] CH_REST  = "R";
    localparam logic [7:0] CASE_BIT = 8'h20;

    // one character waiting to go out, with its phase flags
    typedef struct {
        logic [7:0] ch;
        logic       eos;
        bit         drain;
        bit         calm;
        bit         choke;
    } char_item_t;

    // one result beat as the block should give it
    typedef struct {
        logic [mmnp_pkg::KIND_W-1:0]    kind;
        logic [mmnp_pkg::FREQ_W-1:0]    freq;
        logic [mmnp_pkg::DUR_W-1:0]     dur;
        logic [mmnp_pkg::ERR_POS_W-1:0] pos;
        logic                           last;
    } note_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // char_code
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // freq_hz[14:0], dur_ms[24:15], error_pos[40:25], zeros
    logic [1:0]  m_axis_tuser;        // kind
    logic        m_axis_tlast;

    char_item_t char_q[$];
    note_beat_t due_beats[$];
    note_beat_t step_beats[$];

    // octave zero semitone frequencies, q6.24, and semitone of each note code
    logic [29:0] semi_q24 [14] = '{
        30'd258937088, 30'd274334289, 30'd290647054, 30'd307929828, 30'd326240288,
        30'd345639545, 30'd366192342, 30'd387967272, 30'd411037006, 30'd435478539,
        30'd461373440, 30'd488808132, 30'd517874176, 30'd548668578
    };
    logic [3:0] note_semitone [7] = '{4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd12};

    // parser state as predicted
    logic [1:0]                    p_mode;
    logic [3:0]                    p_octave;
    logic [2:0]                    p_note;
    logic [1:0]                    p_acc;
    logic [6:0]                    p_length;
    bit                            p_pending;
    bit                            p_len_given;
    logic [mmnp_pkg::POS_BITS-1:0] p_pos;

    bit steady = 1'b0;
    bit choke_go = 1'b0;
    bit choked = 1'b0;
    int hold_left = 0;
    bit next_drain = 1'b0;
    bit next_choke = 1'b0;
    bit run_calm = 1'b0;

    int errors = 0;
    int chars_in = 0;
    int tones_seen = 0;
    int dones_seen = 0;
    int errs_seen = 0;
    int phrases = 0;

    music_macro_note_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task report_mismatch(input string what, input longint unsigned got,
                         input longint unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task clear_parser();
        p_mode      = mmnp_pkg::MODE_CMD;
        p_octave    = 4'd4;
        p_note      = 3'd0;
        p_acc       = mmnp_pkg::ACC_NONE;
        p_length    = 7'd1;
        p_pending   = 1'b0;
        p_len_given = 1'b0;
        p_pos       = '0;
    endtask

    function automatic logic [mmnp_pkg::FREQ_W-1:0] tone_hz(input logic [2:0] note,
                                                            input logic [1:0] acc,
                                                            input logic [3:0] octave);
        logic [3:0]      idx;
        longint unsigned scaled;
        begin
            idx = note_semitone[note];
            if (acc == mmnp_pkg::ACC_SHARP)
                idx = idx + 4'd1;
            else if (acc == mmnp_pkg::ACC_FLAT)
                idx = idx - 4'd1;
            scaled = (longint'(semi_q24[idx]) << octave) + (64'd1 << 23);
            tone_hz = mmnp_pkg::FREQ_W'(scaled >> 24);
        end
    endfunction

    // a held note becomes a tone beat unless its length is zero
    task sound_held();
        note_beat_t b;
        if (p_length != 7'd0)
        begin
            b.kind = mmnp_pkg::KIND_TONE;
            b.freq = (p_note == mmnp_pkg::NOTE_REST) ? '0 : tone_hz(p_note, p_acc, p_octave);
            b.dur  = mmnp_pkg::DUR_W'(10'd1000 / p_length);
            b.pos  = '0;
            b.last = 1'b0;
            step_beats.push_back(b);
        end
    endtask

    // predict the beats caused by one character
    task parse_char(input logic [7:0] c, input logic eos);
        logic [7:0]                    up;
        bit                            is_digit;
        bit                            bad;
        logic [mmnp_pkg::POS_BITS-1:0] at;
        note_beat_t                    b;
        step_beats.delete();
        at       = p_pos;
        bad      = 1'b0;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        up       = (c >= "a" && c <= "z") ? c - CASE_BIT : c;

        if (p_mode == mmnp_pkg::MODE_OCT)
        begin
            if (is_digit)
            begin
                p_octave = 4'(c - CH_ZERO);
                p_mode   = mmnp_pkg::MODE_CMD;
            end
            else
                bad = 1'b1;
        end
        else if (p_mode == mmnp_pkg::MODE_CMD)
        begin
            if ((up >= "A" && up <= "G") || up == CH_REST)
            begin
                if (p_pending)
                    sound_held();
                p_note      = (up == CH_REST) ? mmnp_pkg::NOTE_REST
                                              : 3'((up - "A" + 5) % 7);
                p_acc       = mmnp_pkg::ACC_NONE;
                p_length    = 7'd1;
                p_pending   = 1'b1;
                p_len_given = 1'b0;
            end
            else if (up == CH_OCT)
            begin
                if (p_pending)
                begin
                    sound_held();
                    p_pending   = 1'b0;
                    p_len_given = 1'b0;
                end
                p_mode = mmnp_pkg::MODE_OCT;
            end
            else if (p_pending)
            begin
                if (!p_len_given)
                begin
                    if ((c == CH_SHARP || c == CH_PLUS || c == CH_FLAT)
                        && p_note != mmnp_pkg::NOTE_REST)
                        p_acc = (c == CH_FLAT) ? mmnp_pkg::ACC_FLAT : mmnp_pkg::ACC_SHARP;
                    else if (is_digit)
                    begin
                        p_length    = 7'(c - CH_ZERO);
                        p_len_given = 1'b1;
                    end
                    else
                        bad = 1'b1;
                end
                else if (is_digit)
                begin
                    // second digit completes the length and plays the note
                    p_length    = 7'(p_length * 10 + (c - CH_ZERO));
                    sound_held();
                    p_pending   = 1'b0;
                    p_len_given = 1'b0;
                end
                else
                    bad = 1'b1;
            end
        end

        if (bad)
        begin
            b.kind = mmnp_pkg::KIND_ERR;
            b.freq = '0;
            b.dur  = '0;
            b.pos  = mmnp_pkg::ERR_POS_W'(at);
            b.last = 1'b0;
            step_beats.push_back(b);
            p_mode = mmnp_pkg::MODE_SKIP;
        end

        if (p_pos != '1)
            p_pos = p_pos + 1'b1;

        if (eos)
        begin
            if (p_mode != mmnp_pkg::MODE_SKIP)
            begin
                if (p_pending)
                    sound_held();
                b.kind = mmnp_pkg::KIND_DONE;
                b.freq = '0;
                b.dur  = '0;
                b.pos  = '0;
                b.last = 1'b0;
                step_beats.push_back(b);
            end
            clear_parser();
        end

        if (step_beats.size() != 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            due_beats.push_back(step_beats[i]);
    endtask

    task push_char(input logic [7:0] c, input logic eos);
        char_item_t it;
        it.ch    = c;
        it.eos   = eos;
        it.drain = next_drain;
        it.calm  = run_calm;
        it.choke = next_choke;
        next_drain = 1'b0;
        next_choke = 1'b0;
        char_q.push_back(it);
    endtask

    task push_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], ends && (i == s.len() - 1));
    endtask

    // one random phrase, mostly well formed
    task automatic gen_phrase();
        logic [7:0] text[$];
        string      letters = "ABCDEFGR";
        string      accs = "#+-";
        int         r;
        logic [7:0] ch;
        repeat ($urandom_range(1, 5))
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                text.push_back(CH_OCT | ($urandom_range(1) ? CASE_BIT : 8'h00));
                text.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            else if (r < 12)
            begin
                text.push_back(CH_OCT);
                text.push_back(8'($urandom_range(255)));
            end
            else if (r < 15)
                text.push_back(8'($urandom_range(255)));
            else
            begin
                ch = letters[$urandom_range(7)];
                text.push_back(ch | ($urandom_range(1) ? CASE_BIT : 8'h00));
                if ((ch != CH_REST && $urandom_range(99) < 30) || $urandom_range(99) < 4)
                begin
                    text.push_back(accs[$urandom_range(2)]);
                    if ($urandom_range(99) < 15)
                        text.push_back(accs[$urandom_range(2)]);
                end
                r = $urandom_range(99);
                if (r < 55)
                begin
                    text.push_back(CH_ZERO + 8'($urandom_range(9)));
                    if (r < 22)
                    begin
                        text.push_back(CH_ZERO + 8'($urandom_range(9)));
                        if (r < 3)
                            text.push_back(CH_ZERO + 8'($urandom_range(9)));
                    end
                end
            end
        end
        foreach (text[i])
            push_char(text[i], i == text.size() - 1);
    endtask

    // sender: offers queued characters, predicts on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_char(s_axis_tdata, s_axis_tlast);
                chars_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (char_q.size() != 0 && (!char_q[0].drain || due_beats.size() == 0)
                    && (char_q[0].calm || $urandom_range(99) >= 34))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= char_q[0].ch;
                    s_axis_tlast  <= char_q[0].eos;
                    steady        <= char_q[0].calm;
                    if (char_q[0].choke)
                        choke_go <= 1'b1;
                    void'(char_q.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (choke_go && !choked)
        begin
            choked = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(99) >= 34);
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_beats.size() == 0)
                report_mismatch("unexpected beat, kind", m_axis_tuser, 0);
            else
            begin
                if (m_axis_tuser != due_beats[0].kind)
                    report_mismatch("kind", m_axis_tuser, due_beats[0].kind);
                if (m_axis_tdata[14:0] != due_beats[0].freq)
                    report_mismatch("freq_hz", m_axis_tdata[14:0], due_beats[0].freq);
                if (m_axis_tdata[24:15] != due_beats[0].dur)
                    report_mismatch("dur_ms", m_axis_tdata[24:15], due_beats[0].dur);
                if (m_axis_tdata[40:25] != due_beats[0].pos)
                    report_mismatch("error_pos", m_axis_tdata[40:25], due_beats[0].pos);
                if (m_axis_tlast != due_beats[0].last)
                    report_mismatch("tlast", m_axis_tlast, due_beats[0].last);
                void'(due_beats.pop_front());
            end
            if (m_axis_tuser == mmnp_pkg::KIND_TONE)
                tones_seen++;
            else if (m_axis_tuser == mmnp_pkg::KIND_DONE)
                dones_seen++;
            else
                errs_seen++;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        clear_parser();

        // null stray, octave 0, flat on C, third digit ignored
        push_char(8'h00, 1'b0);
        push_text("o0c-9B#+123", 1'b1);
        // octave 9, zero length, rest flushed at the end
        push_text("O9Ad0EfgR", 1'b1);
        // accidental after a rest
        push_text("r#", 1'b1);
        // bad octave digit, then a skipped non-ascii character
        push_text("Ox", 1'b0);
        push_char(8'hFF, 1'b1);

        // random phrases
        while (char_q.size() < ITEM_TARGET)
        begin
            phrases++;
            next_drain = (phrases == 1) || (phrases == 25);
            next_choke = (phrases == 8);
            run_calm   = (phrases >= 14) && (phrases < 21);
            gen_phrase();
        end

        // error after a pending note, sent once everything has drained
        run_calm   = 1'b0;
        next_drain = 1'b1;
        push_text("CXD", 1'b1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!(char_q.size() == 0 && !s_axis_tvalid && due_beats.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d characters in directed strings and %0d random phrases",
                 chars_in, phrases);
        $display("checked %0d tone, %0d done and %0d error beats, with one long output stall",
                 tones_seen, dones_seen, errs_seen);
        if (errors == 0)
            $display("music_macro_note_parser_tb: clean");
        else
            $display("music_macro_note_parser_tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #30_000_000;
        $display("timeout with %0d beats still expected", due_beats.size());
        $display("music_macro_note_parser_tb: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/mmnp_pkg.sv
rtl/mmnp_ctrl.sv
rtl/mmnp_dp.sv
rtl/music_macro_note_parser.sv
test/music_macro_note_parser_tb.sv
